### hdl/hrp_pkg.sv
// Shared types, constants and the hex digit decoder for the HEX record parser.
`timescale 1ns / 1ps

package hrp_pkg;

	localparam int MAX_WORDS = 8;
	localparam int MAX_BYTES = 2 * MAX_WORDS;

	localparam int POS_W   = 6;
	localparam int BCNT_W  = 5;
	localparam int IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	// character positions inside a record
	localparam logic [POS_W-1:0] POS_COUNT_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0] POS_COUNT_LAST  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_ADDR_FIRST  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_ADDR_LAST   = POS_W'(6);
	localparam logic [POS_W-1:0] POS_TYPE        = POS_W'(8);
	localparam logic [POS_W-1:0] POS_DATA_FIRST  = POS_W'(9);

	localparam logic [7:0]  CH_TYPE_DATA = 8'h30;	// '0'
	localparam logic [7:0]  CH_TYPE_EXT  = 8'h34;	// '4'
	localparam logic [15:0] UPPER_RESET  = 16'h0800;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_UPPER = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [31:0]       target_address;
		logic [IDX_W-1:0]  word_index;
		logic [15:0]       word_value;
		logic [BCNT_W-1:0] byte_count;
		logic              digit_error;
		logic              last;
	} result_t;

	// up to two results from one character; a single one always sits in r0
	typedef struct packed {
		logic    valid0;
		logic    valid1;
		result_t r0;
		result_t r1;
	} push_t;

	typedef struct packed {
		logic [3:0] value;
		logic       bad;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.bad = 1'b0;
		if (c inside {[8'h30:8'h39]}) begin
			h.value = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			h.value = 4'(c[3:0] + 4'd9);
		end else begin
			h.value = 4'd0;
			h.bad   = 1'b1;
		end
		return h;
	endfunction

endpackage

### hdl/hrp_core.sv
// Input register stage and per-character record decoding with parser state.
`timescale 1ns / 1ps

module hrp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  logic [7:0]            ch,
	input  logic                  starts_record,
	input  logic                  room,
	output hrp_pkg::push_t        push
);

	logic                          valid_s1;
	logic [7:0]                    ch_s1;
	logic                          start_s1;

	logic [hrp_pkg::POS_W-1:0]     pos_q, pos_d;
	logic                          active_q, active_d;
	logic [7:0]                    count_q, count_d;
	logic [15:0]                   low_q, low_d;
	logic [15:0]                   upper_q, upper_d;
	logic [15:0]                   acc_q, acc_d;
	logic [hrp_pkg::IDX_W-1:0]     idx_q, idx_d;
	logic                          err_q, err_d;

	logic                          work;
	hrp_pkg::hex_t                 hx;
	logic [hrp_pkg::BCNT_W-1:0]    eff;
	logic [hrp_pkg::POS_W-1:0]     d_idx;
	logic [hrp_pkg::POS_W:0]       d_plus;
	logic                          data_hit, end_hit;
	hrp_pkg::kind_t                end_kind;
	hrp_pkg::result_t              data_res, end_res;

	assign stall = valid_s1 && !room;
	assign work  = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			ch_s1    <= ch;
			start_s1 <= starts_record;
		end
	end

	assign hx     = hrp_pkg::hex_value(ch_s1);
	assign eff    = (count_q > 8'(hrp_pkg::MAX_BYTES)) ? hrp_pkg::BCNT_W'(hrp_pkg::MAX_BYTES)
	                                                   : count_q[hrp_pkg::BCNT_W-1:0];
	assign d_idx  = pos_q - hrp_pkg::POS_DATA_FIRST;
	assign d_plus = {1'b0, d_idx} + (hrp_pkg::POS_W+1)'(1);

	always_comb begin
		pos_d    = pos_q;
		active_d = active_q;
		count_d  = count_q;
		low_d    = low_q;
		upper_d  = upper_q;
		acc_d    = acc_q;
		idx_d    = idx_q;
		err_d    = err_q;
		data_hit = 1'b0;
		end_hit  = 1'b0;
		end_kind = hrp_pkg::KIND_DONE;

		if (start_s1) begin
			pos_d    = hrp_pkg::POS_COUNT_FIRST;
			active_d = 1'b1;
			count_d  = '0;
			low_d    = '0;
			acc_d    = '0;
			idx_d    = '0;
			err_d    = 1'b0;
		end else if (active_q) begin
			if (pos_q >= hrp_pkg::POS_COUNT_FIRST && pos_q <= hrp_pkg::POS_COUNT_LAST) begin
				count_d = {count_q[3:0], hx.value};
				err_d   = err_q | hx.bad;
			end else if (pos_q >= hrp_pkg::POS_ADDR_FIRST && pos_q <= hrp_pkg::POS_ADDR_LAST) begin
				low_d = {low_q[11:0], hx.value};
				err_d = err_q | hx.bad;
			end else if (pos_q == hrp_pkg::POS_TYPE) begin
				err_d = err_q | (count_q > 8'(hrp_pkg::MAX_BYTES));
				if (ch_s1 == hrp_pkg::CH_TYPE_EXT) begin
					// staged upper always equals the low address digits
					upper_d  = low_q;
					end_hit  = 1'b1;
					end_kind = hrp_pkg::KIND_UPPER;
				end else if (ch_s1 == hrp_pkg::CH_TYPE_DATA) begin
					end_hit  = (eff == '0);
					end_kind = hrp_pkg::KIND_DONE;
				end else begin
					end_hit  = 1'b1;
					end_kind = hrp_pkg::KIND_OTHER;
				end
			end else if (pos_q >= hrp_pkg::POS_DATA_FIRST) begin
				acc_d    = {acc_q[11:0], hx.value};
				err_d    = err_q | hx.bad;
				data_hit = (d_idx[1:0] == 2'b11);
				if (data_hit) begin
					idx_d = idx_q + hrp_pkg::IDX_W'(1);
				end
				end_hit  = (d_plus >= {1'b0, eff, 1'b0});
				end_kind = hrp_pkg::KIND_DONE;
			end
			if (end_hit) begin
				active_d = 1'b0;
			end else begin
				pos_d = pos_q + hrp_pkg::POS_W'(1);
			end
		end

		data_res.kind           = hrp_pkg::KIND_DATA;
		data_res.target_address = {upper_q, low_q};
		data_res.word_index     = idx_q;
		data_res.word_value     = acc_d;
		data_res.byte_count     = eff;
		data_res.digit_error    = err_d;
		data_res.last           = !end_hit;

		end_res.kind            = end_kind;
		end_res.target_address  = {upper_d, low_q};
		end_res.word_index      = '0;
		end_res.word_value      = '0;
		end_res.byte_count      = eff;
		end_res.digit_error     = err_d;
		end_res.last            = 1'b1;

		push.valid0 = work && (data_hit || end_hit);
		push.valid1 = work && data_hit && end_hit;
		push.r0     = data_hit ? data_res : end_res;
		push.r1     = end_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			active_q <= 1'b0;
			count_q  <= '0;
			low_q    <= '0;
			upper_q  <= hrp_pkg::UPPER_RESET;
			acc_q    <= '0;
			idx_q    <= '0;
			err_q    <= 1'b0;
		end else if (work) begin
			pos_q    <= pos_d;
			active_q <= active_d;
			count_q  <= count_d;
			low_q    <= low_d;
			upper_q  <= upper_d;
			acc_q    <= acc_d;
			idx_q    <= idx_d;
			err_q    <= err_d;
		end
	end

endmodule

### hdl/hrp_out_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
`timescale 1ns / 1ps

module hrp_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  hrp_pkg::push_t   push,
	output logic             room,
	output logic             valid,
	input  logic             stall,
	output hrp_pkg::result_t head
);

	hrp_pkg::result_t             mem_q [hrp_pkg::QUEUE_DEPTH];
	logic [hrp_pkg::QPTR_W-1:0]   wp_q, rp_q;
	logic [hrp_pkg::QCNT_W-1:0]   cnt_q;
	logic                         pop;
	logic [hrp_pkg::QCNT_W-1:0]   n_push;

	assign valid  = (cnt_q != '0);
	assign pop    = valid && !stall;
	assign head   = mem_q[rp_q];
	assign room   = (cnt_q <= hrp_pkg::QCNT_W'(hrp_pkg::QUEUE_DEPTH - 2));
	assign n_push = hrp_pkg::QCNT_W'(push.valid0) + hrp_pkg::QCNT_W'(push.valid1);

	always_ff @(posedge clk) begin
		if (push.valid0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.valid1) begin
			mem_q[wp_q + hrp_pkg::QPTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[hrp_pkg::QPTR_W-1:0];
			if (pop) begin
				rp_q <= rp_q + hrp_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - hrp_pkg::QCNT_W'(pop);
		end
	end

endmodule

### hdl/hex_record_parser.sv
// Top level of the streaming HEX record parser.
`timescale 1ns / 1ps
//
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// record    | rec_valid, rec_stall | ch, starts_record (one character/transfer)
// result    | res_valid, res_stall | kind, target_address, word_index,
//           |                      | word_value, byte_count, digit_error, last
//
// One character per cycle while rec_stall is low: a character is registered,
// then decoded against the parser state once the queue has room, and its
// results land in a four-entry queue. A character ending the last halfword of
// a data record yields two results, and both enter the queue together.
// rec_stall rises only while a registered character waits for two free queue
// entries; a stalled result side fills the queue and then backs up the input.
// Reset is asynchronous: no record is active and the upper address is 0x0800.
// The upper address held by the parser survives from record to record.

module hex_record_parser (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        rec_valid,
	output logic        rec_stall,
	input  logic [7:0]  ch,
	input  logic        starts_record,

	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [31:0] target_address,
	output logic [2:0]  word_index,
	output logic [15:0] word_value,
	output logic [4:0]  byte_count,
	output logic        digit_error,
	output logic        last
);

	hrp_pkg::push_t   push;
	hrp_pkg::result_t head;
	logic             room;

	// decode stage: owns all record state
	hrp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (rec_valid),
		.stall         (rec_stall),
		.ch            (ch),
		.starts_record (starts_record),
		.room          (room),
		.push          (push)
	);

	// result queue: holds finished results until the result side takes them
	hrp_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (res_valid),
		.stall  (res_stall),
		.head   (head)
	);

	assign kind           = head.kind;
	assign target_address = head.target_address;
	assign word_index     = head.word_index;
	assign word_value     = head.word_value;
	assign byte_count     = head.byte_count;
	assign digit_error    = head.digit_error;
	assign last           = head.last;

endmodule
